@@ src/hcd_pkg.sv @@
// hcd_pkg: shared types and constants for the tcp header change detector
// no dependencies; imported by the ecn tracker, the id classifier and the top level
`default_nettype none

package hcd_pkg;

  // header geometry and wrap points
  localparam logic [15:0] HdrBytes   = 16'd40;
  localparam logic [15:0] MsnLast    = 16'hfffe;
  localparam int          IdMaxDelta = 20;
  localparam logic [3:0]  LimitReset = 4'd3;

  // ip-id behavior codes as seen on the result
  typedef enum logic [1:0] {
    IdSequential = 2'd0,
    IdSwapped    = 2'd1,
    IdZero       = 2'd2,
    IdRandom     = 2'd3
  } id_class_e;

  // header fields of one packet, last field in the lowest bits
  typedef struct packed {
    logic [15:0] packet_length;
    logic [3:0]  tcp_reserved_flags;
    logic [1:0]  tcp_ecn_flags;
    logic [1:0]  ip_ecn_bits;
    logic [15:0] ip_id_field;
  } hdr_t;

  // ecn decision handed from the tracker to the top level
  typedef struct packed {
    logic mark;
    logic in_use;
  } ecn_result_t;

endpackage

`default_nettype wire

@@ src/hcd_ecn_tracker.sv @@
// hcd_ecn_tracker: ecn-used flag with hysteresis counters and reserved-flag history
// depends on hcd_pkg
`default_nettype none

module hcd_ecn_tracker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic [3:0]          limit_i,
  input  wire logic [1:0]          ecn_vals_i,
  input  wire logic [3:0]          reserved_i,
  output hcd_pkg::ecn_result_t     result_o
);
  import hcd_pkg::*;

  logic       ecn_flag_q, ecn_flag_d;
  logic [3:0] change_cnt_q, change_cnt_d;
  logic [3:0] zero_cnt_q, zero_cnt_d;
  logic [3:0] prev_res_q;
  logic       res_changed, by_res, by_unset, by_set, mark;

  // change conditions for this packet
  assign res_changed = (reserved_i != prev_res_q);
  assign by_res      = res_changed && !ecn_flag_q;
  assign by_unset    = (ecn_vals_i == 2'b00) && ecn_flag_q;
  assign by_set      = (ecn_vals_i != 2'b00) && !ecn_flag_q;

  // hysteresis decision
  always_comb begin
    ecn_flag_d   = ecn_flag_q;
    change_cnt_d = change_cnt_q;
    zero_cnt_d   = zero_cnt_q;
    mark         = 1'b0;
    if (by_res || by_unset || by_set) begin
      if (by_unset && (zero_cnt_q < limit_i)) begin
        zero_cnt_d = zero_cnt_q + 4'd1;
      end else begin
        mark         = 1'b1;
        ecn_flag_d   = (ecn_vals_i != 2'b00) || res_changed;
        change_cnt_d = '0;
        zero_cnt_d   = '0;
      end
    end else if (change_cnt_q < limit_i) begin
      mark         = 1'b1;
      change_cnt_d = change_cnt_q + 4'd1;
      zero_cnt_d   = '0;
    end else begin
      zero_cnt_d = '0;
    end
  end

  // mark in the upper bit, in_use in the lower bit
  assign result_o = {mark, ecn_flag_d};

  // state advances once per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecn_flag_q   <= 1'b0;
      change_cnt_q <= '0;
      zero_cnt_q   <= '0;
      prev_res_q   <= '0;
    end else if (fire_i) begin
      ecn_flag_q   <= ecn_flag_d;
      change_cnt_q <= change_cnt_d;
      zero_cnt_q   <= zero_cnt_d;
      prev_res_q   <= reserved_i;
    end
  end

endmodule

`default_nettype wire

@@ src/hcd_id_classifier.sv @@
// hcd_id_classifier: ip-id behavior class against the previous packet's id
// depends on hcd_pkg
`default_nettype none

module hcd_id_classifier (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic [15:0]         ip_id_i,
  output hcd_pkg::id_class_e       class_o
);
  import hcd_pkg::*;

  localparam logic [15:0] WrapBase = 16'hffff - 16'(IdMaxDelta);

  logic [15:0] prev_id_q;
  logic        first_q;

  // true when nw follows od by a small step, wrapping near the top
  function automatic logic id_increasing(input logic [15:0] od, input logic [15:0] nw);
    logic inc;
    inc = 1'b0;
    if ((nw > od) && ((nw - od) < 16'(IdMaxDelta))) inc = 1'b1;
    if ((od > WrapBase) && ((nw > od) || (nw < (od - WrapBase)))) inc = 1'b1;
    return inc;
  endfunction

  // classification
  always_comb begin
    if (first_q) begin
      class_o = IdSequential;
    end else if (id_increasing(prev_id_q, ip_id_i)) begin
      class_o = IdSequential;
    end else if (id_increasing({prev_id_q[7:0], prev_id_q[15:8]},
                               {ip_id_i[7:0], ip_id_i[15:8]})) begin
      class_o = IdSwapped;
    end else if (ip_id_i == 16'd0) begin
      class_o = IdZero;
    end else begin
      class_o = IdRandom;
    end
  end

  // id history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_id_q <= '0;
      first_q   <= 1'b1;
    end else if (fire_i) begin
      prev_id_q <= ip_id_i;
      first_q   <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ src/tcp_header_change_detector.sv @@
// tcp_header_change_detector: top level with input register, msn and result register
// depends on hcd_pkg, hcd_ecn_tracker, hcd_id_classifier
`default_nettype none

// One parsed IPv4/TCP header goes in per transfer and one result comes out per
// header, at a sustained rate of one item every clock cycle while the output is
// not stalled. An item passes through the input register and then the result
// register; the ecn counters, id history and msn all update in the cycle that
// moves an item from the input register into the result register. While the
// input register is empty, a header is taken while a result waits downstream.
// The repeat limit is written through the cfg channel, which is always ready, and
// should only be changed while no item is in flight.

module tcp_header_change_detector (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write: fo_repeat_limit
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i,
  // header input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // ip_id_field[15:0], ip_ecn_bits[17:16], tcp_ecn_flags[19:18],
  // tcp_reserved_flags[23:20], packet_length[39:24]
  input  wire logic [39:0] s_axis_tdata,
  // result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // ecn_in_use[0], ecn_change_mark[1], ip_id_class[3:2],
  // sequence_number[19:4], payload_length[35:20], zero pad[39:36]
  output logic [39:0]      m_axis_tdata
);
  import hcd_pkg::*;

  logic        cfg_fire;
  logic [3:0]  fo_limit_q;
  logic        in_valid_q;
  hdr_t        in_hdr_q;
  logic        out_valid_q;
  logic [39:0] out_data_q, out_data_d;
  logic [15:0] msn_q, msn_d;
  logic [15:0] data_bytes;
  logic        out_free, advance;
  ecn_result_t ecn_res;
  id_class_e   id_class;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // repeat limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fo_limit_q <= LimitReset;
    end else if (cfg_fire) begin
      fo_limit_q <= cfg_data_i;
    end
  end

  // flow control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_hdr_q <= hdr_t'(s_axis_tdata);
    end
  end

  hcd_ecn_tracker u_ecn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .limit_i    (fo_limit_q),
    .ecn_vals_i (in_hdr_q.ip_ecn_bits | in_hdr_q.tcp_ecn_flags),
    .reserved_i (in_hdr_q.tcp_reserved_flags),
    .result_o   (ecn_res)
  );

  hcd_id_classifier u_id (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .ip_id_i (in_hdr_q.ip_id_field),
    .class_o (id_class)
  );

  // message sequence number wraps from 0xfffe to zero
  assign msn_d = (msn_q == MsnLast) ? 16'd0 : msn_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msn_q <= '0;
    end else if (advance) begin
      msn_q <= msn_d;
    end
  end

  // payload length, zero for runt packets
  assign data_bytes = (in_hdr_q.packet_length >= HdrBytes) ?
                      (in_hdr_q.packet_length - HdrBytes) : 16'd0;

  assign out_data_d = {4'b0000, data_bytes, msn_d, id_class, ecn_res.mark, ecn_res.in_use};

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ src/hcd_checker.sv @@
// hcd_checker: port-level assertions for tcp_header_change_detector, bound to it
// depends on the top level's port list only
`default_nettype none

module hcd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // with the result side empty the input side must be ready
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // once an accepted header has passed the input register, a result is valid
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("accepted header produced no result");

  // msn never reaches 0xffff and padding stays zero
  a_msn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[19:4] != 16'hffff) && (m_axis_tdata[39:36] == 4'd0))
    else $error("sequence number or padding out of range");

endmodule

bind tcp_header_change_detector hcd_checker u_hcd_checker (.*);

`default_nettype wire
